// ===== rtl/sfvm_pkg.sv =====
// Shared types, codes and default sizes of the stack frame VM executor.
package sfvm_pkg;

  // Default sizes handed to the top level parameters
  localparam int unsigned FRAME_BYTES_DEF = 32;
  localparam int unsigned CALL_DEPTH_DEF  = 8;
  localparam int unsigned MEM_BYTES_DEF   = 256;

  // Fixed register numbers
  localparam logic [2:0] IMM_REG = 3'd4;
  localparam logic [2:0] PC_REG  = 3'd7;

  typedef enum logic [3:0] {
    OP_MOV   = 4'd0,
    OP_CAL   = 4'd1,
    OP_RET   = 4'd2,
    OP_REF   = 4'd3,
    OP_ADD   = 4'd4,
    OP_PRINT = 4'd5,
    OP_NOT   = 4'd6,
    OP_EQU   = 4'd7
  } opcode_e;

  typedef enum logic [1:0] {
    OPND_IMM  = 2'd0,
    OPND_REG  = 2'd1,
    OPND_SLOT = 2'd2,
    OPND_PTR  = 2'd3
  } opnd_e;

  typedef enum logic [2:0] {
    STAT_DONE     = 3'd0,
    STAT_PRINT    = 3'd1,
    STAT_HALT     = 3'd2,
    STAT_INVALID  = 3'd3,
    STAT_OVERFLOW = 3'd4
  } status_e;

  // Execution sequencer states
  typedef enum logic [2:0] {
    S_IDLE,   // no instruction held
    S_EXEC,   // entry state: source side, or ops that finish here
    S_SPTR,   // source pointer byte returned
    S_SDAT,   // source data byte returned
    S_DST,    // destination side
    S_DPTR,   // destination pointer byte returned
    S_DDAT,   // print data byte returned
    S_ADD     // second register read of ADD
  } seq_state_e;

  typedef struct packed {
    logic [3:0] opcode;
    logic [1:0] dest_type;
    logic [7:0] dest_value;
    logic [1:0] src_type;
    logic [7:0] src_value;
  } instr_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] print_value;
    logic [7:0] next_counter;
    logic [7:0] frame_label;
  } result_t;

endpackage

// ===== rtl/sfvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sfvm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sfvm_exec.sv =====
// Instruction sequencer: register file, call stack and data memory access.
module sfvm_exec #(
  parameter int unsigned FRAME_BYTES = sfvm_pkg::FRAME_BYTES_DEF,
  parameter int unsigned CALL_DEPTH  = sfvm_pkg::CALL_DEPTH_DEF,
  parameter int unsigned MEM_BYTES   = sfvm_pkg::MEM_BYTES_DEF,
  localparam int unsigned AW         = $clog2(MEM_BYTES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                instr_valid_i,
  input  sfvm_pkg::instr_t    instr_i,
  output logic                take_o,
  input  logic                out_free_i,
  output logic                res_valid_o,
  output sfvm_pkg::result_t   res_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  logic [7:0]          mem_rdata_i,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output logic [7:0]          mem_wdata_o
);

  localparam int unsigned DW = $clog2(CALL_DEPTH);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(CALL_DEPTH - 1);
  localparam logic [10:0] MOD1 = 11'(MEM_BYTES);
  localparam logic [10:0] MOD2 = 11'(2 * MEM_BYTES);
  localparam logic [10:0] MOD4 = 11'(4 * MEM_BYTES);
  localparam int unsigned FSTEP = FRAME_BYTES % MEM_BYTES;
  localparam int unsigned FBACK = (MEM_BYTES - FSTEP) % MEM_BYTES;

  // Reduce a value below 8*MEM_BYTES into the address range
  function automatic logic [AW-1:0] wrap_addr(input logic [9:0] v);
    logic [10:0] t;
    t = {1'b0, v};
    if (t >= MOD4) t = t - MOD4;
    if (t >= MOD2) t = t - MOD2;
    if (t >= MOD1) t = t - MOD1;
    return t[AW-1:0];
  endfunction

  sfvm_pkg::seq_state_e state_q, state_d;
  sfvm_pkg::instr_t     ir_q;
  logic [7:0]           x_q, x_d;

  logic [7:0]    regs_q   [8];
  logic [7:0]    labels_q [CALL_DEPTH];
  logic [7:0]    rc_q     [CALL_DEPTH];
  logic [DW-1:0] depth_q;
  logic [AW-1:0] base_q;
  logic [7:0]    cur_label_q;
  logic          halted_q;

  logic [2:0]    rd, rs;
  logic [DW-1:0] depth_dec;
  logic [AW-1:0] src_slot, dst_slot, ptr_addr;

  logic          fin, commit;
  logic [2:0]    rf_raddr;
  logic [7:0]    rf_rdata;
  logic          rf_we;
  logic [2:0]    rf_waddr;
  logic [7:0]    rf_wdata;
  logic          bump, do_cal, do_ret, set_halt;
  logic          mem_we;
  logic [2:0]    status;
  logic [7:0]    pv;
  logic [7:0]    pc_after_w, pc_new, label_new;

  assign rd        = ir_q.dest_value[2:0];
  assign rs        = ir_q.src_value[2:0];
  assign depth_dec = depth_q - DW'(1);
  assign src_slot  = wrap_addr(10'(base_q) + 10'(ir_q.src_value));
  assign dst_slot  = wrap_addr(10'(base_q) + 10'(ir_q.dest_value));
  assign ptr_addr  = wrap_addr(10'(mem_rdata_i));

  // Register read port: MOV and ADD read the source register in S_EXEC
  assign rf_raddr = (state_q == sfvm_pkg::S_EXEC &&
                     (ir_q.opcode == sfvm_pkg::OP_MOV || ir_q.opcode == sfvm_pkg::OP_ADD))
                    ? rs : rd;
  assign rf_rdata = regs_q[rf_raddr];

  // Sequencer: next state, operand moves and commit controls
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    fin         = 1'b0;
    rf_we       = 1'b0;
    rf_waddr    = rd;
    rf_wdata    = x_q;
    bump        = 1'b0;
    do_cal      = 1'b0;
    do_ret      = 1'b0;
    set_halt    = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = src_slot;
    mem_we      = 1'b0;
    mem_waddr_o = dst_slot;
    mem_wdata_o = x_q;
    status      = sfvm_pkg::STAT_DONE;
    pv          = 8'd0;

    unique case (state_q)
      sfvm_pkg::S_IDLE: begin
      end

      sfvm_pkg::S_EXEC: begin
        if (halted_q) begin
          fin    = 1'b1;
          status = sfvm_pkg::STAT_HALT;
        end else begin
          unique case (ir_q.opcode)
            sfvm_pkg::OP_MOV: begin
              unique case (ir_q.src_type)
                sfvm_pkg::OPND_IMM: begin
                  rf_we    = 1'b1;
                  rf_waddr = sfvm_pkg::IMM_REG;
                  rf_wdata = ir_q.src_value;
                  x_d      = ir_q.src_value;
                  state_d  = sfvm_pkg::S_DST;
                end
                sfvm_pkg::OPND_REG: begin
                  x_d      = rf_rdata;
                  state_d  = sfvm_pkg::S_DST;
                end
                sfvm_pkg::OPND_SLOT: begin
                  mem_re_o = 1'b1;
                  state_d  = sfvm_pkg::S_SDAT;
                end
                sfvm_pkg::OPND_PTR: begin
                  mem_re_o = 1'b1;
                  state_d  = sfvm_pkg::S_SPTR;
                end
              endcase
            end
            sfvm_pkg::OP_REF: begin
              unique case (ir_q.src_type) inside
                sfvm_pkg::OPND_IMM, sfvm_pkg::OPND_REG: begin
                  fin    = 1'b1;
                  status = sfvm_pkg::STAT_INVALID;
                end
                sfvm_pkg::OPND_SLOT: begin
                  x_d     = 8'(src_slot);
                  state_d = sfvm_pkg::S_DST;
                end
                sfvm_pkg::OPND_PTR: begin
                  mem_re_o = 1'b1;
                  state_d  = sfvm_pkg::S_SPTR;
                end
              endcase
            end
            sfvm_pkg::OP_PRINT: begin
              state_d = sfvm_pkg::S_DST;
            end
            sfvm_pkg::OP_ADD: begin
              x_d      = rf_rdata;
              state_d  = sfvm_pkg::S_ADD;
            end
            sfvm_pkg::OP_NOT: begin
              fin      = 1'b1;
              rf_we    = 1'b1;
              rf_wdata = ~rf_rdata;
              bump     = 1'b1;
            end
            sfvm_pkg::OP_EQU: begin
              fin      = 1'b1;
              rf_we    = 1'b1;
              rf_wdata = (rf_rdata == 8'd0) ? 8'd1 : 8'd0;
              bump     = 1'b1;
            end
            sfvm_pkg::OP_CAL: begin
              fin = 1'b1;
              if (depth_q == DEPTH_MAX) begin
                set_halt = 1'b1;
                status   = sfvm_pkg::STAT_OVERFLOW;
              end else begin
                do_cal = 1'b1;
              end
            end
            sfvm_pkg::OP_RET: begin
              fin = 1'b1;
              if (depth_q == '0) begin
                set_halt = 1'b1;
                status   = sfvm_pkg::STAT_HALT;
              end else begin
                do_ret = 1'b1;
              end
            end
            default: begin
              fin    = 1'b1;
              status = sfvm_pkg::STAT_INVALID;
            end
          endcase
        end
      end

      // Source pointer byte in hand: REF keeps the address, MOV reads through it
      sfvm_pkg::S_SPTR: begin
        if (ir_q.opcode == sfvm_pkg::OP_REF) begin
          x_d     = 8'(ptr_addr);
          state_d = sfvm_pkg::S_DST;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_addr;
          state_d     = sfvm_pkg::S_SDAT;
        end
      end

      sfvm_pkg::S_SDAT: begin
        x_d     = mem_rdata_i;
        state_d = sfvm_pkg::S_DST;
      end

      sfvm_pkg::S_DST: begin
        mem_raddr_o = dst_slot;
        if (ir_q.opcode == sfvm_pkg::OP_PRINT) begin
          unique case (ir_q.dest_type)
            sfvm_pkg::OPND_IMM: begin
              fin      = 1'b1;
              rf_we    = 1'b1;
              rf_waddr = sfvm_pkg::IMM_REG;
              rf_wdata = ir_q.dest_value;
              pv       = ir_q.dest_value;
              status   = sfvm_pkg::STAT_PRINT;
              bump     = 1'b1;
            end
            sfvm_pkg::OPND_REG: begin
              fin    = 1'b1;
              pv     = rf_rdata;
              status = sfvm_pkg::STAT_PRINT;
              bump   = 1'b1;
            end
            sfvm_pkg::OPND_SLOT: begin
              mem_re_o = 1'b1;
              state_d  = sfvm_pkg::S_DDAT;
            end
            sfvm_pkg::OPND_PTR: begin
              mem_re_o = 1'b1;
              state_d  = sfvm_pkg::S_DPTR;
            end
          endcase
        end else begin
          unique case (ir_q.dest_type)
            sfvm_pkg::OPND_IMM: begin
              fin      = 1'b1;
              rf_we    = 1'b1;
              rf_waddr = sfvm_pkg::IMM_REG;
              bump     = 1'b1;
            end
            sfvm_pkg::OPND_REG: begin
              fin   = 1'b1;
              rf_we = 1'b1;
              bump  = 1'b1;
            end
            sfvm_pkg::OPND_SLOT: begin
              fin    = 1'b1;
              mem_we = 1'b1;
              bump   = 1'b1;
            end
            sfvm_pkg::OPND_PTR: begin
              mem_re_o = 1'b1;
              state_d  = sfvm_pkg::S_DPTR;
            end
          endcase
        end
      end

      // Destination pointer byte in hand
      sfvm_pkg::S_DPTR: begin
        if (ir_q.opcode == sfvm_pkg::OP_PRINT) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_addr;
          state_d     = sfvm_pkg::S_DDAT;
        end else begin
          fin         = 1'b1;
          mem_we      = 1'b1;
          mem_waddr_o = ptr_addr;
          bump        = 1'b1;
        end
      end

      sfvm_pkg::S_DDAT: begin
        fin    = 1'b1;
        pv     = mem_rdata_i;
        status = sfvm_pkg::STAT_PRINT;
        bump   = 1'b1;
      end

      sfvm_pkg::S_ADD: begin
        fin      = 1'b1;
        rf_we    = 1'b1;
        rf_wdata = rf_rdata + x_q;
        bump     = 1'b1;
      end

      default: begin
        state_d = sfvm_pkg::S_IDLE;
      end
    endcase

    // A finishing word waits for room in the output register
    commit = !fin || out_free_i;
    take_o = (state_q == sfvm_pkg::S_IDLE) || (fin && out_free_i);
    if (take_o) begin
      state_d = instr_valid_i ? sfvm_pkg::S_EXEC : sfvm_pkg::S_IDLE;
    end else if (!commit) begin
      state_d = state_q;
    end
  end

  assign mem_we_o = mem_we && commit;

  // Counter after the step
  always_comb begin
    pc_after_w = (rf_we && rf_waddr == sfvm_pkg::PC_REG) ? rf_wdata : regs_q[sfvm_pkg::PC_REG];
    if (do_cal) begin
      pc_new = 8'd0;
    end else if (do_ret) begin
      pc_new = rc_q[depth_dec] + 8'd1;
    end else if (bump) begin
      pc_new = pc_after_w + 8'd1;
    end else begin
      pc_new = pc_after_w;
    end
    if (do_cal) begin
      label_new = ir_q.dest_value;
    end else if (do_ret) begin
      label_new = labels_q[depth_dec];
    end else begin
      label_new = cur_label_q;
    end
  end

  assign res_valid_o        = fin && out_free_i;
  assign res_o.status       = status;
  assign res_o.print_value  = pv;
  assign res_o.next_counter = pc_new;
  assign res_o.frame_label  = label_new;

  // Machine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfvm_pkg::S_IDLE;
      depth_q     <= '0;
      base_q      <= '0;
      cur_label_q <= 8'd0;
      halted_q    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        regs_q[i] <= 8'd0;
      end
      for (int i = 0; i < CALL_DEPTH; i++) begin
        labels_q[i] <= 8'd0;
        rc_q[i]     <= 8'd0;
      end
    end else begin
      state_q <= state_d;
      if (commit) begin
        // the counter register takes pc_new, which already folds in its write
        if (rf_we && rf_waddr != sfvm_pkg::PC_REG) begin
          regs_q[rf_waddr] <= rf_wdata;
        end
        regs_q[sfvm_pkg::PC_REG] <= pc_new;
        cur_label_q <= label_new;
        if (set_halt) begin
          halted_q <= 1'b1;
        end
        if (do_cal) begin
          rc_q[depth_q]                <= regs_q[sfvm_pkg::PC_REG];
          labels_q[depth_q + DW'(1)]   <= ir_q.dest_value;
          depth_q                      <= depth_q + DW'(1);
          base_q                       <= wrap_addr(10'(base_q) + 10'(FSTEP));
        end
        if (do_ret) begin
          depth_q <= depth_dec;
          base_q  <= wrap_addr(10'(base_q) + 10'(FBACK));
        end
      end
    end
  end

  // Instruction and operand holding registers
  always_ff @(posedge clk_i) begin
    if (take_o && instr_valid_i) begin
      ir_q <= instr_i;
    end
    x_q <= x_d;
  end

endmodule

// ===== rtl/stack_frame_vm_executor.sv =====
// Top level: input word register, memory clearing pass, sequencer, data RAM, output register.
// Pointer operands cost dependent data RAM reads (one read port, registered read data),
// and each word starts when the previous one commits.
// Reset clears registers and call stack at once, then zeroes the data RAM one byte per cycle
// over all MEM_BYTES addresses with in_stall_o high.
module stack_frame_vm_executor #(
  parameter int unsigned FRAME_BYTES = sfvm_pkg::FRAME_BYTES_DEF,
  parameter int unsigned CALL_DEPTH  = sfvm_pkg::CALL_DEPTH_DEF,
  parameter int unsigned MEM_BYTES   = sfvm_pkg::MEM_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] opcode_i,
  input  logic [1:0] dest_type_i,
  input  logic [7:0] dest_value_i,
  input  logic [1:0] src_type_i,
  input  logic [7:0] src_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [7:0] print_value_o,
  output logic [7:0] next_counter_o,
  output logic [7:0] frame_label_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);

  logic              buf_valid_q;
  sfvm_pkg::instr_t  buf_q;
  logic              in_accept;
  logic              take;

  logic              clr_q;
  logic [AW-1:0]     clr_cnt_q;

  logic              out_valid_q;
  sfvm_pkg::result_t out_q;
  logic              out_free;
  logic              res_valid;
  sfvm_pkg::result_t res;

  logic              seq_re, seq_we;
  logic [AW-1:0]     seq_raddr, seq_waddr;
  logic [7:0]        seq_wdata, ram_rdata;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;

  // Input word register, refilled in the cycle the sequencer takes it
  assign in_stall_o = clr_q || (buf_valid_q && !take);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else if (in_accept) begin
      buf_valid_q <= 1'b1;
    end else if (take) begin
      buf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      buf_q.opcode     <= opcode_i;
      buf_q.dest_type  <= dest_type_i;
      buf_q.dest_value <= dest_value_i;
      buf_q.src_type   <= src_type_i;
      buf_q.src_value  <= src_value_i;
    end
  end

  // Clearing pass over the data RAM after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == CLR_LAST) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign ram_we    = clr_q || seq_we;
  assign ram_waddr = clr_q ? clr_cnt_q : seq_waddr;
  assign ram_wdata = clr_q ? 8'd0 : seq_wdata;

  sfvm_exec #(
    .FRAME_BYTES (FRAME_BYTES),
    .CALL_DEPTH  (CALL_DEPTH),
    .MEM_BYTES   (MEM_BYTES)
  ) u_exec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .instr_valid_i (buf_valid_q),
    .instr_i       (buf_q),
    .take_o        (take),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .mem_re_o      (seq_re),
    .mem_raddr_o   (seq_raddr),
    .mem_rdata_i   (ram_rdata),
    .mem_we_o      (seq_we),
    .mem_waddr_o   (seq_waddr),
    .mem_wdata_o   (seq_wdata)
  );

  sfvm_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (seq_re),
    .raddr_i (seq_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign print_value_o  = out_q.print_value;
  assign next_counter_o = out_q.next_counter;
  assign frame_label_o  = out_q.frame_label;

endmodule
